// ===== hdl/cq_pkg.sv =====
// ----------------------------------------------------------------------------
// cq_pkg
// Shared types and constants for the circular queue front and back ends.
// ----------------------------------------------------------------------------
package cq_pkg;

  localparam int DefaultDepth = 8;
  localparam int WordW        = 32;
  localparam int CmdQDepth    = 2;
  localparam int CmdQAw       = $clog2(CmdQDepth);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SHOW = 2'd3
  } cq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cq_status_e;

  typedef struct packed {
    cq_op_e                    op;
    logic signed [WordW-1:0]   value;
  } cq_cmd_t;

endpackage

// ===== hdl/cq_front.sv =====
// ----------------------------------------------------------------------------
// cq_front
// Accepts requests, decodes the operation and holds them in a short
// command queue until the back end takes them.
// ----------------------------------------------------------------------------
module cq_front import cq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                    cmd_valid_o,
  output cq_cmd_t                 cmd_o,
  input  logic                    cmd_pop_i
);

  cq_cmd_t             entries_q [CmdQDepth];
  logic [CmdQAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CmdQAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CmdQAw:0]     fill_q, fill_d;
  logic                push;
  cq_cmd_t             cmd_new;

  always_comb begin
    cmd_new.value = push_value_i;
    cmd_new.op    = cq_op_e'(operation_i);
  end

  assign in_stall_o  = (fill_q == (CmdQAw+1)'(CmdQDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !cmd_pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/cq_back.sv =====
// ----------------------------------------------------------------------------
// cq_back
// Executes queued commands against the ring store and drives the result
// register; display walks the ring one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
module cq_back import cq_pkg::*; #(
  parameter int Depth = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  cq_cmd_t                 cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] value_o,
  output logic                    last_o
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Cw = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [Aw-1:0]           head_q, head_d;
  logic [Aw-1:0]           tail_q, tail_d;
  logic [Aw-1:0]           walk_q, walk_d;
  logic [Cw-1:0]           count_q, count_d;
  logic [Cw-1:0]           remain_q, remain_d;
  logic                    drop_q, drop_d;
  logic                    out_valid_q, out_valid_d;
  cq_status_e              out_status_q, out_status_d;
  logic signed [WordW-1:0] out_value_q, out_value_d;
  logic                    out_last_q, out_last_d;
  logic signed [WordW-1:0] mem [Depth];
  logic signed [WordW-1:0] rd_data_q;
  logic                    wr_en, rd_en;
  logic [Aw-1:0]           rd_addr;
  logic                    out_free;

  function automatic logic [Aw-1:0] ring_next(input logic [Aw-1:0] idx);
    ring_next = (idx == Aw'(Depth - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && out_free;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    walk_d       = walk_q;
    count_d      = count_q;
    remain_d     = remain_q;
    drop_d       = drop_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          case (cmd_i.op)
            OP_ENQ: begin
              out_valid_d = 1'b1;
              out_value_d = '0;
              out_last_d  = 1'b1;
              if (count_q == Cw'(Depth)) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_OK;
                wr_en        = 1'b1;
                tail_d       = ring_next(tail_q);
                count_d      = count_q + 1'b1;
              end
            end
            default: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_EMPTY;
                out_value_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                // first read goes out now, data is ready in the walk state
                rd_en    = 1'b1;
                rd_addr  = head_q;
                walk_d   = ring_next(head_q);
                remain_d = (cmd_i.op == OP_SHOW) ? count_q : Cw'(1);
                drop_d   = (cmd_i.op == OP_DEQ);
                state_d  = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_value_d  = rd_data_q;
          out_last_d   = (remain_q == Cw'(1));
          if (remain_q == Cw'(1)) begin
            state_d = S_IDLE;
            if (drop_q) begin
              head_d  = ring_next(head_q);
              count_d = count_q - 1'b1;
            end
          end else begin
            rd_en    = 1'b1;
            rd_addr  = walk_q;
            walk_d   = ring_next(walk_q);
            remain_d = remain_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      walk_q      <= '0;
      count_q     <= '0;
      remain_q    <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      walk_q      <= walk_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/circular_queue.sv =====
// ----------------------------------------------------------------------------
// circular_queue
// Ring-buffer FIFO of signed words with enqueue, dequeue, peek and display.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time.
// Enqueue, and any request that finds the queue empty, gives its result in
// the cycle after the back end takes it. Dequeue and peek give the head
// from the walk state; display walks the ring there, one entry per cycle
// unless the output stalls, as the ring store has a single registered read
// port and each entry needs its own read. Results sit in an output register,
// so new requests are still accepted while a result waits for transfer.
module circular_queue import cq_pkg::*; #(
  parameter int Depth = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] value_o,
  output logic                    last_o
);

  logic    cmd_valid;
  logic    cmd_pop;
  cq_cmd_t cmd;

  cq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  cq_back #(
    .Depth (Depth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule

// ===== verif/circular_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_queue_tb
// Drives enqueue, dequeue, peek and display requests into the ring-buffer
// queue with random gaps and output stalls. A local copy of the ring predicts
// each result, and every transfer on the output side is checked against it.
// ----------------------------------------------------------------------------
module circular_queue_tb;
  import cq_pkg::*;

  localparam int RingDepth = DefaultDepth;

  typedef struct {
    cq_status_e              status;
    logic signed [WordW-1:0] value;
    logic                    last;
  } ring_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              operation_i = OP_ENQ;
  logic signed [WordW-1:0] push_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;
  logic signed [WordW-1:0] value_o;
  logic                    last_o;

  circular_queue #(
    .Depth(RingDepth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .push_value_i(push_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted ring contents
  logic signed [WordW-1:0] ring_slots[RingDepth];
  int                      ring_head = 0;
  int                      ring_tail = 0;
  int                      ring_count = 0;

  cq_cmd_t      pending_cmds[$];
  ring_result_t due_results[$];
  int           errors = 0;
  int           n_accepted = 0;
  int           n_issued = 0;
  int           n_results = 0;
  int           n_seen = 0;
  bit           in_busy = 1'b0;
  bit           in_quiet = 1'b0;
  bit           out_quiet = 1'b0;
  int           in_gap = 0;
  int           out_wait = 0;

  task automatic due_push(input cq_status_e st, input logic signed [WordW-1:0] word,
                          input logic is_last);
    ring_result_t r;
    r.status = st;
    r.value  = word;
    r.last   = is_last;
    due_results.push_back(r);
  endtask

  task automatic ring_apply(input cq_op_e op, input logic signed [WordW-1:0] word);
    int idx;
    case (op)
      OP_ENQ: begin
        if (ring_count == RingDepth) begin
          due_push(ST_FULL, '0, 1'b1);
        end else begin
          ring_slots[ring_tail] = word;
          ring_tail = (ring_tail + 1) % RingDepth;
          ring_count++;
          due_push(ST_OK, '0, 1'b1);
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (ring_count == 0) begin
          due_push(ST_EMPTY, '0, 1'b1);
        end else begin
          due_push(ST_OK, ring_slots[ring_head], 1'b1);
          if (op == OP_DEQ) begin
            ring_head = (ring_head + 1) % RingDepth;
            ring_count--;
          end
        end
      end
      default: begin
        if (ring_count == 0) begin
          due_push(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = ring_head;
          for (int n = 0; n < ring_count; n++) begin
            due_push(ST_OK, ring_slots[idx], n == ring_count - 1);
            idx = (idx + 1) % RingDepth;
          end
        end
      end
    endcase
  endtask

  task automatic queue_cmd(input cq_op_e op, input logic signed [WordW-1:0] word);
    cq_cmd_t c;
    c.op    = op;
    c.value = word;
    pending_cmds.push_back(c);
  endtask

  // request side: predict on every accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ring_apply(cq_op_e'(operation_i), push_value_i);
      n_accepted++;
    end
  end

  // result side: compare with the oldest prediction
  always @(posedge clk_i) begin
    ring_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none,", $time,
                 " got status %0d value %h last %b", status_o, value_o, last_o);
      end else begin
        e = due_results.pop_front();
        if (status_o !== e.status || value_o !== e.value || last_o !== e.last) begin
          errors++;
          $display("%0t: mismatch: expected status %0d value %h last %b,",
                   $time, e.status, e.value, e.last,
                   " got status %0d value %h last %b", status_o, value_o, last_o);
        end
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    cq_cmd_t c;
    if (rst_ni) begin
      if (in_busy && n_accepted == n_issued) begin
        in_busy = 1'b0;
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 9);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          operation_i  <= c.op;
          push_value_i <= c.value;
          n_issued++;
          in_busy = 1'b1;
        end
      end
      in_valid_i <= in_busy;
    end
  end

  // result stall, redrawn after every transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (n_results != n_seen) begin
        n_seen = n_results;
        if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 9);
      end
      out_stall_i <= (out_wait != 0);
      if (out_wait != 0) out_wait--;
    end
  end

  initial begin
    cq_op_e op;
    int     pick;
    int     n_items;
    bit     fill;

    // empty queue, then fill to the brim with extreme words
    queue_cmd(OP_SHOW, 32'h0000_0000);
    queue_cmd(OP_DEQ, 32'hFFFF_FFFF);
    queue_cmd(OP_PEEK, 32'h7FFF_FFFF);
    queue_cmd(OP_ENQ, 32'h8000_0000);
    queue_cmd(OP_PEEK, 32'h0000_0000);
    queue_cmd(OP_ENQ, 32'h7FFF_FFFF);
    queue_cmd(OP_ENQ, 32'h0000_0000);
    queue_cmd(OP_ENQ, 32'hFFFF_FFFF);
    queue_cmd(OP_ENQ, 32'hAAAA_AAAA);
    queue_cmd(OP_ENQ, 32'h5555_5555);
    queue_cmd(OP_ENQ, 32'h0000_0001);
    queue_cmd(OP_ENQ, 32'h1234_5678);
    // full: the word is dropped
    queue_cmd(OP_ENQ, 32'hDEAD_BEEF);
    queue_cmd(OP_SHOW, 32'h8000_0000);
    queue_cmd(OP_DEQ, 32'h0000_0000);
    queue_cmd(OP_DEQ, 32'h0000_0000);
    // tail wraps round the ring, and the display walks across its end
    queue_cmd(OP_ENQ, 32'hFEDC_BA98);
    queue_cmd(OP_ENQ, 32'h0F0F_F0F0);
    queue_cmd(OP_SHOW, 32'h0000_0000);
    queue_cmd(OP_PEEK, 32'h0000_0000);
    repeat (5) queue_cmd(OP_DEQ, $urandom());

    // alternate filling and draining so both ends of the ring get reached
    for (int ph = 0; ph < 5; ph++) begin
      fill = (ph % 2 == 0);
      repeat (18) begin
        pick = $urandom_range(0, 99);
        if (pick < (fill ? 65 : 20)) op = OP_ENQ;
        else if (pick < (fill ? 80 : 75)) op = OP_DEQ;
        else if (pick < 90) op = OP_PEEK;
        else op = OP_SHOW;
        queue_cmd(op, $urandom());
      end
    end
    n_items = pending_cmds.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_accepted != n_items || due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== circular_queue.f =====
hdl/cq_pkg.sv
hdl/cq_front.sv
hdl/cq_back.sv
hdl/circular_queue.sv
verif/circular_queue_tb.sv
